// File: sv/sha256_pkg.sv
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// Depends on nothing; imported by every other file of the block.
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OREAD,
        ST_OWAIT
    } t_state;

    typedef struct packed {
        logic [2:0]  addr;
        logic [2:0]  waddr;
        logic        we;
        logic [31:0] wdata;
        logic        clr;
    } t_mem_req;

    typedef struct packed {
        logic        push_word;
        logic [31:0] word;
        logic        shift_var;
        logic [31:0] var_in;
        logic        use_a;
        logic        round;
        logic [31:0] k;
    } t_core_ctrl;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            3'd7: init_h = 32'h5be0cd19;
            default: init_h = 32'h0;
        endcase
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// File: sv/sha256_hash_mem.sv
// Eight-entry hash word memory: one write port, one read port with registered read.
// Per-entry valid bits make unwritten entries read as the initial hash values.
`default_nettype none
module sha256_hash_mem (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha256_pkg::t_mem_req i_req,
    output logic [31:0]               o_rdata
);
    import sha256_pkg::*;

    logic [31:0] r_mem [8];
    logic [7:0]  r_valid;
    logic [31:0] r_rdata;
    logic        r_rvalid;
    logic [2:0]  r_raddr;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
        r_raddr <= i_req.addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[i_req.addr];
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end else if (i_req.clr) begin
                r_valid[i_req.addr] <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : init_h(r_raddr);
endmodule
`default_nettype wire

// File: sv/sha256_core.sv
// Message schedule shift line, working variables and the round function.
// Depends on sha256_pkg for the control struct and rotate helper.
`default_nettype none
module sha256_core (
    input  wire logic                   i_clk,
    input  wire sha256_pkg::t_core_ctrl i_ctrl,
    output logic [31:0]                 o_a
);
    import sha256_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] w_new, s0, s1, ch, maj, t1, t2, g0, g1;

    always_comb begin
        g0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        g1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + g0 + r_w[9] + g1;
        s1    = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + s1 + ch + i_ctrl.k + r_w[0];
        s0    = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = s0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push_word || i_ctrl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= i_ctrl.round ? w_new : i_ctrl.word;
        end
        if (i_ctrl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (i_ctrl.shift_var) begin
            for (int i = 0; i < 7; i++) begin
                r_v[i] <= r_v[i + 1];
            end
            r_v[7] <= i_ctrl.use_a ? r_v[0] : i_ctrl.var_in;
        end
    end

    assign o_a = r_v[0];
endmodule
`default_nettype wire

// File: sv/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level: control sequencer and stream ports.
// Depends on sha256_pkg, sha256_hash_mem and sha256_core.
//
// Input stream: s_axis_tdata carries a message byte, s_axis_tuser marks it
// as part of the message, s_axis_tlast closes the message after that byte.
// Output stream: eight digest words per message, word 0 first, tlast on 7.
// Bytes are taken one per cycle while a block fills. Each full block then
// holds the input while the working variables are loaded from the hash
// word memory, 64 rounds run and the results are added back into the
// memory. At message end padding is fed one byte a cycle up to the block
// end (plus a second compression when over 55 bytes were pending), then
// the eight words go out one at a time from the hash memory read port.
// A stalled receiver holds the output register; the next word is not read
// until it is taken, and input is accepted once the last word is loaded.
// Reset clears the hash memory valid bits so it reads the initial values.
`default_nettype none
module sha256_byte_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_number
    output logic             m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_cnt;
    logic [5:0]  r_bib;
    logic [60:0] r_count;
    logic [23:0] r_word;
    logic        r_eom, r_padding, r_first, r_len_ok;
    logic        r_ovalid, r_olast;
    logic [31:0] r_odata;
    logic [2:0]  r_onum;

    logic        in_acc, out_acc, push_en;
    logic [7:0]  push_byte, len_byte;
    logic [63:0] len_bits;
    logic [31:0] rdata, a_val;
    t_mem_req    mem_req;
    t_core_ctrl  ctrl;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign len_bits = {r_count, 3'b000};
    assign len_byte = 8'(len_bits >> {3'd7 - r_bib[2:0], 3'b000});

    always_comb begin
        n_state   = r_state;
        push_en   = 1'b0;
        push_byte = s_axis_tdata;
        mem_req   = '{addr: r_cnt[2:0], waddr: r_cnt[2:0] - 3'd1, we: 1'b0,
                      wdata: rdata + a_val, clr: 1'b0};
        case (r_state)
            ST_IDLE: begin
                push_en = in_acc && s_axis_tuser;
                if (push_en && r_bib == 6'd63) begin
                    n_state = ST_LOAD;
                end else if (in_acc && s_axis_tlast) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (r_first) begin
                    push_byte = PAD_BYTE;
                end else if (r_len_ok && r_bib >= LEN_POS) begin
                    push_byte = len_byte;
                end else begin
                    push_byte = 8'h00;
                end
                if (r_bib == 6'd63) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (r_cnt == 6'd8) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_cnt == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                mem_req.we = (r_cnt != 6'd0);
                if (r_cnt == 6'd8) begin
                    if (r_padding) begin
                        n_state = r_len_ok ? ST_OREAD : ST_PAD;
                    end else begin
                        n_state = r_eom ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_OREAD: begin
                if (!r_ovalid) begin
                    mem_req.clr = 1'b1;
                    n_state     = ST_OWAIT;
                end
            end
            ST_OWAIT: begin
                n_state = (r_cnt[2:0] == 3'd7) ? ST_IDLE : ST_OREAD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.push_word = push_en && (r_bib[1:0] == 2'd3);
        ctrl.word      = {r_word, push_byte};
        ctrl.shift_var = ((r_state == ST_LOAD) || (r_state == ST_ADD)) && (r_cnt != 6'd0);
        ctrl.var_in    = rdata;
        ctrl.use_a     = (r_state == ST_ADD);
        ctrl.round     = (r_state == ST_ROUND);
        ctrl.k         = ROUND_K[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_bib     <= '0;
            r_count   <= '0;
            r_eom     <= 1'b0;
            r_padding <= 1'b0;
            r_first   <= 1'b0;
            r_len_ok  <= 1'b0;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
        end else begin
            if (push_en) begin
                r_word <= {r_word[15:0], push_byte};
                r_bib  <= r_bib + 6'd1;
            end
            if (r_state == ST_IDLE && in_acc) begin
                r_eom <= s_axis_tlast;
                if (s_axis_tuser) begin
                    r_count <= r_count + 61'd1;
                end
            end
            if (n_state == ST_PAD && r_state != ST_PAD && !r_padding) begin
                r_padding <= 1'b1;
                r_first   <= 1'b1;
            end
            if (r_state == ST_PAD) begin
                r_first <= 1'b0;
                if (r_first) begin
                    r_len_ok <= (r_bib < LEN_POS);
                end
            end
            if (r_state == ST_ADD && r_cnt == 6'd8 && r_padding) begin
                r_len_ok <= 1'b1;
            end
            if (r_state == ST_OWAIT) begin
                r_cnt <= r_cnt + 6'd1;
            end else if (r_state != ST_OREAD) begin
                if (n_state != r_state) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            if (n_state == ST_OREAD && r_state == ST_ADD) begin
                r_padding <= 1'b0;
                r_len_ok  <= 1'b0;
                r_eom     <= 1'b0;
                r_count   <= '0;
            end
            if (r_state == ST_OWAIT) begin
                r_ovalid <= 1'b1;
                r_olast  <= (r_cnt[2:0] == 3'd7);
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OWAIT) begin
            r_odata <= rdata;
            r_onum  <= r_cnt[2:0];
        end
    end

    sha256_hash_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    sha256_core u_core (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .o_a    (a_val)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b00000, r_onum, r_odata};
    assign m_axis_tlast  = r_olast;

    a_last_is_seven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[34:32] == 3'd7))
        else $error("tlast on a word other than the eighth");

    a_no_read_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OWAIT) |-> !$past(r_ovalid))
        else $error("digest word read while output register full");

    a_round_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_cnt == 6'd0) |-> ($past(r_state) == ST_ROUND))
        else $error("final addition entered without rounds");
endmodule
`default_nettype wire
